// ----- hw/rtl/complex_spinor_dot_product_defines.svh -----
// Assertion macros used by complex_spinor_dot_product.sv to check its own logic.
`ifndef COMPLEX_SPINOR_DOT_PRODUCT_DEFINES_SVH
`define COMPLEX_SPINOR_DOT_PRODUCT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CSDP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CSDP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/csdp_pkg.sv -----
`default_nettype none

package csdp_pkg;

  localparam int Q_W   = 24;
  localparam int P_W   = 2 * Q_W;
  localparam int T_W   = P_W + 1;
  localparam int ACC_W = 64;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [P_W-1:0]   prod_t;
  typedef logic signed [T_W-1:0]   term_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Valid and end-of-vector mark that travel with each pipeline stage.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  typedef struct packed {
    acc_t sum;
    logic ovf;
  } sat_sum_t;

  // Saturating add of a 49-bit term to a 64-bit accumulator.
  function automatic sat_sum_t sat_add(acc_t acc, term_t term);
    acc_t     t;
    acc_t     s;
    sat_sum_t r;
    t = {{(ACC_W-T_W){term[T_W-1]}}, term};
    s = acc + t;
    if ((acc[ACC_W-1] == t[ACC_W-1]) && (s[ACC_W-1] != acc[ACC_W-1])) begin
      r.sum = acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
      r.ovf = 1'b1;
    end else begin
      r.sum = s;
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/csdp_if.sv -----
`default_nettype none

interface csdp_in_if;
  logic            valid;
  logic            ready;
  csdp_pkg::q_t    r_real;
  csdp_pkg::q_t    r_imag;
  csdp_pkg::q_t    s_real;
  csdp_pkg::q_t    s_imag;
  logic            last_component;

  modport source (output valid, r_real, r_imag, s_real, s_imag, last_component,
                  input ready);
  modport sink   (input valid, r_real, r_imag, s_real, s_imag, last_component,
                  output ready);
endinterface

interface csdp_out_if;
  logic            valid;
  logic            ready;
  csdp_pkg::acc_t  sum_real;
  csdp_pkg::acc_t  sum_imag;
  logic            saturated;

  modport source (output valid, sum_real, sum_imag, saturated, input ready);
  modport sink   (input valid, sum_real, sum_imag, saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/complex_spinor_dot_product.sv -----
// Channel  | Dir | Payload                                        | Request
// ---------+-----+------------------------------------------------+------------------
// comp     | in  | r_real, r_imag, s_real, s_imag, last_component | one component pair
// result   | out | sum_real, sum_imag, saturated                  | one sum per vector
//
// One request is taken every cycle while the pipeline does not stall; each accumulator feeds back through its register.
// A result reaches the output register after its last component has passed the input, product and term registers.
// The pipeline stalls only when a last component reaches the accumulators
// while the previous result is still waiting in the output register.
// Reset is synchronous and clears the accumulators, the flag and all valids.
`default_nettype none
`include "complex_spinor_dot_product_defines.svh"

module complex_spinor_dot_product (
  input  wire logic  clk,
  input  wire logic  rst,
  csdp_in_if.sink    comp,
  csdp_out_if.source result
);

  logic                 en;
  csdp_pkg::stage_ctl_t ctl_in;
  csdp_pkg::stage_ctl_t ctl_acc;
  csdp_pkg::q_t         r_real;
  csdp_pkg::q_t         r_imag;
  csdp_pkg::q_t         s_real;
  csdp_pkg::q_t         s_imag;
  csdp_pkg::term_t      re_term;
  csdp_pkg::term_t      im_term;
  csdp_pkg::acc_t       real_acc;
  csdp_pkg::acc_t       imag_acc;
  logic                 ovf_seen;
  csdp_pkg::sat_sum_t   re_next;
  csdp_pkg::sat_sum_t   im_next;
  logic                 acc_step;
  logic                 out_load;
  logic                 out_valid;

  assign en         = !(ctl_acc.valid && ctl_acc.last && out_valid && !result.ready);
  assign comp.ready = en;
  assign acc_step   = en && ctl_acc.valid;
  assign out_load   = acc_step && ctl_acc.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_in <= '0;
    end else if (en) begin
      ctl_in.valid <= comp.valid;
      ctl_in.last  <= comp.last_component;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_real <= comp.r_real;
      r_imag <= comp.r_imag;
      s_real <= comp.s_real;
      s_imag <= comp.s_imag;
    end
  end

  csdp_terms u_terms (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_in),
    .r_real  (r_real),
    .r_imag  (r_imag),
    .s_real  (s_real),
    .s_imag  (s_imag),
    .ctl_out (ctl_acc),
    .re_term (re_term),
    .im_term (im_term)
  );

  always_comb begin
    re_next = csdp_pkg::sat_add(real_acc, re_term);
    im_next = csdp_pkg::sat_add(imag_acc, im_term);
  end

  // The last component is accumulated, its sums go to the output register
  // and the accumulators start again from zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      real_acc <= '0;
      imag_acc <= '0;
      ovf_seen <= 1'b0;
    end else if (out_load) begin
      real_acc <= '0;
      imag_acc <= '0;
      ovf_seen <= 1'b0;
    end else if (acc_step) begin
      real_acc <= re_next.sum;
      imag_acc <= im_next.sum;
      ovf_seen <= ovf_seen | re_next.ovf | im_next.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.sum_real  <= re_next.sum;
      result.sum_imag  <= im_next.sum;
      result.saturated <= ovf_seen | re_next.ovf | im_next.ovf;
    end
  end

  assign result.valid = out_valid;

  `CSDP_ASSERT(a_stall_only_on_full_output, clk, rst, !comp.ready |-> (ctl_acc.valid && ctl_acc.last && out_valid), "input stalled without a waiting result")
  `CSDP_ASSERT(a_clear_after_result, clk, rst, out_load |=> (real_acc == '0 && imag_acc == '0 && !ovf_seen), "accumulators not cleared after a result")
  `CSDP_ASSERT_ALWAYS(a_flag_means_limit, clk, (!rst && $rose(ovf_seen)) |-> (real_acc == csdp_pkg::ACC_MAX || real_acc == csdp_pkg::ACC_MIN || imag_acc == csdp_pkg::ACC_MAX || imag_acc == csdp_pkg::ACC_MIN), "overflow flag set without a clamped accumulator")

endmodule

`default_nettype wire

// ----- hw/rtl/csdp_terms.sv -----
`default_nettype none

// Two pipeline stages: four registered products, then the registered
// real and imaginary terms.
module csdp_terms (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire csdp_pkg::stage_ctl_t ctl_in,
  input  wire csdp_pkg::q_t         r_real,
  input  wire csdp_pkg::q_t         r_imag,
  input  wire csdp_pkg::q_t         s_real,
  input  wire csdp_pkg::q_t         s_imag,
  output csdp_pkg::stage_ctl_t      ctl_out,
  output csdp_pkg::term_t           re_term,
  output csdp_pkg::term_t           im_term
);

  csdp_pkg::stage_ctl_t ctl_prod;
  csdp_pkg::prod_t      rr_sr;
  csdp_pkg::prod_t      ri_si;
  csdp_pkg::prod_t      ri_sr;
  csdp_pkg::prod_t      rr_si;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_prod <= '0;
      ctl_out  <= '0;
    end else if (en) begin
      ctl_prod <= ctl_in;
      ctl_out  <= ctl_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_sr   <= r_real * s_real;
      ri_si   <= r_imag * s_imag;
      ri_sr   <= r_imag * s_real;
      rr_si   <= r_real * s_imag;
      re_term <= {rr_sr[csdp_pkg::P_W-1], rr_sr} + {ri_si[csdp_pkg::P_W-1], ri_si};
      im_term <= {ri_sr[csdp_pkg::P_W-1], ri_sr} - {rr_si[csdp_pkg::P_W-1], rr_si};
    end
  end

endmodule

`default_nettype wire
